FILE: sv/rrl_pkg.sv
// shared types and constants for the retransmit ring lookup block
`default_nettype none
package rrl_pkg;

	localparam int RING_DEPTH       = 256;
	localparam int MAX_PACKET_BYTES = 1472;

	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int SIZE_W     = SLOT_W + 1;
	localparam int NUM_W      = 8;
	localparam int LEN_W      = 11;
	localparam int STATUS_W   = 3;
	localparam int CFG_SIZE_W = 9;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RESEND_DISABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STANDBY         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE    = 2'd2;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_RESEND = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_RECORDED  = 3'd0,
		ST_RESENT    = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_ALREADY   = 3'd3,
		ST_DISABLED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic [NUM_W-1:0] origin;
		logic [LEN_W-1:0] length;
	} entry_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] write_slot;
		logic [SLOT_W-1:0] copy_from_slot;
		logic [NUM_W-1:0]  packet_number;
		logic [NUM_W-1:0]  original_number;
		logic [LEN_W-1:0]  packet_length;
		logic              transmit;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		entry_t            wdata;
		logic [SLOT_W-1:0] raddr;
	} ram_req_t;

endpackage
`default_nettype wire

FILE: sv/rrl_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module rrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/rrl_ctrl.sv
// sequencer, slot occupancy, ring pointers and the backward search compare
`default_nettype none
module rrl_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [rrl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rrl_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             operation,
	input  wire logic [rrl_pkg::LEN_W-1:0]        packet_length,
	input  wire logic [rrl_pkg::NUM_W-1:0]        requested_number,
	output rrl_pkg::ram_req_t                     ram_req,
	input  wire rrl_pkg::entry_t                  ram_rdata,
	input  wire logic                             out_free,
	output logic                                  commit,
	output rrl_pkg::result_t                      result
);
	import rrl_pkg::*;

	state_t state_q, state_d;

	logic                  resend_disabled_q;
	logic                  standby_q;
	logic [CFG_SIZE_W-1:0] slots_in_use_q;

	logic [SLOT_W-1:0] next_slot_q;
	logic [NUM_W-1:0]  next_number_q;
	logic [RING_DEPTH-1:0] occ_q;
	logic              pend_q;

	logic              op_q;
	logic [NUM_W-1:0]  req_q;
	logic [LEN_W-1:0]  len_q;
	logic [SLOT_W-1:0] ns_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] pidx_q;
	logic [SLOT_W-1:0] found_q;
	status_t           status_q;

	logic [SIZE_W-1:0] n;
	logic [SLOT_W-1:0] ns_cur;
	logic [SLOT_W-1:0] start_idx;
	logic [SLOT_W-1:0] idx_dec;
	logic [SIZE_W-1:0] ns_inc;
	logic [SLOT_W-1:0] ns_next;
	logic [LEN_W-1:0]  len_sat;
	logic              accept;
	logic              cand_ok;
	logic              hit_num;
	logic              hit_org;
	logic              search_done;
	logic              wr_ok;

	// ring size in effect, clamped to one .. depth
	always_comb begin
		if (slots_in_use_q == '0) begin
			n = SIZE_W'(1);
		end else if (slots_in_use_q > CFG_SIZE_W'(RING_DEPTH)) begin
			n = SIZE_W'(RING_DEPTH);
		end else begin
			n = SIZE_W'(slots_in_use_q);
		end
	end

	assign ns_cur    = ({1'b0, next_slot_q} >= n) ? '0 : next_slot_q;
	assign start_idx = (ns_cur == '0) ? SLOT_W'(n - SIZE_W'(1)) : ns_cur - SLOT_W'(1);
	assign idx_dec   = (idx_q == '0) ? SLOT_W'(n - SIZE_W'(1)) : idx_q - SLOT_W'(1);
	assign ns_inc    = {1'b0, ns_q} + SIZE_W'(1);
	assign ns_next   = (ns_inc >= n) ? '0 : ns_inc[SLOT_W-1:0];
	assign len_sat   = (packet_length > LEN_W'(MAX_PACKET_BYTES)) ?
		LEN_W'(MAX_PACKET_BYTES) : packet_length;

	// search stops on a number or origin match, at an empty slot or at the slot about to be reused
	assign cand_ok     = (idx_q != ns_q) && occ_q[idx_q];
	assign hit_num     = pend_q && (ram_rdata.number == req_q);
	assign hit_org     = pend_q && (ram_rdata.origin == req_q);
	assign search_done = hit_num || hit_org || !cand_ok;
	assign wr_ok       = (status_q == ST_RECORDED) || (status_q == ST_RESENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept = 1'b1;
					if (operation == OP_RESEND && !resend_disabled_q) begin
						state_d = S_SEARCH;
					end else begin
						state_d = S_COMMIT;
					end
				end
			end
			S_SEARCH: begin
				if (search_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resend_disabled_q <= 1'b0;
			standby_q         <= 1'b0;
			slots_in_use_q    <= CFG_SIZE_W'(RING_DEPTH);
			next_slot_q       <= '0;
			next_number_q     <= '0;
			occ_q             <= '0;
			pend_q            <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RESEND_DISABLED: resend_disabled_q <= cfg_data[0];
					CFG_STANDBY:         standby_q         <= cfg_data[0];
					CFG_SLOTS_IN_USE:    slots_in_use_q    <= cfg_data[CFG_SIZE_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				next_slot_q <= ns_cur;
			end
			pend_q <= (state_q == S_SEARCH) && !search_done;
			if (commit && wr_ok) begin
				occ_q[ns_q]   <= (len_q != '0);
				next_slot_q   <= ns_next;
				next_number_q <= next_number_q + NUM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			req_q   <= requested_number;
			len_q   <= len_sat;
			ns_q    <= ns_cur;
			idx_q   <= start_idx;
			found_q <= '0;
			if (operation == OP_RECORD) begin
				status_q <= ST_RECORDED;
			end else if (resend_disabled_q) begin
				status_q <= ST_DISABLED;
			end else begin
				status_q <= ST_NOT_FOUND;
			end
		end else if (state_q == S_SEARCH) begin
			priority if (hit_num) begin
				status_q <= ST_RESENT;
				found_q  <= pidx_q;
				len_q    <= ram_rdata.length;
			end else if (hit_org) begin
				status_q <= ST_ALREADY;
			end else if (cand_ok) begin
				pidx_q <= idx_q;
				idx_q  <= idx_dec;
			end else begin
			end
		end
	end

	// one read issued per search cycle, data compared the cycle after
	always_comb begin
		ram_req.we           = commit && wr_ok;
		ram_req.waddr        = ns_q;
		ram_req.wdata.number = next_number_q;
		ram_req.wdata.origin = (op_q == OP_RECORD) ? next_number_q : req_q;
		ram_req.wdata.length = len_q;
		ram_req.raddr        = idx_q;
	end

	always_comb begin
		result = '0;
		result.status = status_q;
		if (wr_ok) begin
			result.write_slot      = ns_q;
			result.copy_from_slot  = found_q;
			result.packet_number   = next_number_q;
			result.original_number = (op_q == OP_RECORD) ? next_number_q : req_q;
			result.packet_length   = len_q;
			result.transmit        = !standby_q;
		end
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> out_free)
		else $error("result committed while output register busy");

	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (state_q == S_IDLE))
		else $error("sequencer not idle after commit");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> ({1'b0, idx_q} < n))
		else $error("search index outside ring");

	a_ns_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> ({1'b0, ns_q} < n))
		else $error("write slot outside ring");

	a_pend_search: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> ($past(state_q) == S_SEARCH))
		else $error("read pending outside search");

endmodule
`default_nettype wire

FILE: sv/retransmit_ring_lookup_core.sv
// a record's result passes from accept through the commit state into the output register; a resend searches first
// resend search reads one slot per cycle through the single ram read port
// one request in flight; the next is accepted the cycle after its result is committed
// so records are taken one at a time and wait in the commit state while the result side stalls
// async reset sets config to its defaults and clears ring pointers and per-slot occupancy bits at once
// slot ram contents are not cleared, no clearing pass is needed
`default_nettype none
module retransmit_ring_lookup_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rrl_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          operation,
	input  wire logic [rrl_pkg::LEN_W-1:0]     packet_length,
	input  wire logic [rrl_pkg::NUM_W-1:0]     requested_number,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [rrl_pkg::STATUS_W-1:0]       status,
	output logic [rrl_pkg::SLOT_W-1:0]         write_slot,
	output logic [rrl_pkg::SLOT_W-1:0]         copy_from_slot,
	output logic [rrl_pkg::NUM_W-1:0]          packet_number,
	output logic [rrl_pkg::NUM_W-1:0]          original_number,
	output logic [rrl_pkg::LEN_W-1:0]          packet_length_out,
	output logic                               transmit
);
	import rrl_pkg::*;

	ram_req_t ram_req;
	entry_t   ram_rdata;
	logic     out_free;
	logic     commit;
	result_t  result;
	result_t  result_q;
	logic     out_valid_q;

	rrl_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(RING_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	rrl_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.packet_length   (packet_length),
		.requested_number(requested_number),
		.ram_req         (ram_req),
		.ram_rdata       (ram_rdata),
		.out_free        (out_free),
		.commit          (commit),
		.result          (result)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q <= result;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = result_q.status;
	assign write_slot        = result_q.write_slot;
	assign copy_from_slot    = result_q.copy_from_slot;
	assign packet_number     = result_q.packet_number;
	assign original_number   = result_q.original_number;
	assign packet_length_out = result_q.packet_length;
	assign transmit          = result_q.transmit;

endmodule
`default_nettype wire
